// ===== rtl/core/rit_pkg.sv =====
package rit_pkg;

  // Width of the converted integer
  localparam int VALUE_BITS = 32;
  localparam int RADIX_BITS = 8;
  localparam int CHAR_BITS  = 7;

  // Most digits any conversion can give (base two, magnitude 2^(VALUE_BITS-1))
  localparam int MAX_DIGITS = VALUE_BITS;
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

  // Base limits and digit width (base up to 16 fits in 5 bits, a digit in 4)
  localparam int BASE_W  = 5;
  localparam int DIGIT_W = 4;
  localparam int STACK_W = MAX_DIGITS * DIGIT_W;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 8'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 8'd16;
  localparam logic [RADIX_BITS-1:0] SIGNED_RADIX = 8'd10;

  // Character codes
  localparam logic [CHAR_BITS-1:0] MINUS_CODE  = 7'h2D;
  localparam logic [CHAR_BITS-1:0] ZERO_CODE   = 7'h30;
  localparam logic [CHAR_BITS-1:0] ALPHA_BASE  = 7'h57;
  localparam logic [CHAR_BITS-1:0] BAD_CODE    = 7'h00;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0]        radix;
  } in_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last_char;
    logic                 bad_radix;
  } out_t;

  // Map a digit to its lower-case ASCII character
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_BITS-1:0] dx;
    dx = {{(CHAR_BITS-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return ZERO_CODE + dx;
    end else begin
      return ALPHA_BASE + dx;
    end
  endfunction

endpackage

// ===== rtl/core/radix_integer_to_text.sv =====
// Converts a signed integer to lower-case ASCII digits in bases 2 to 16, most
// significant digit first, one character per out_strobe cycle; a '-' leads
// negative values in base ten and last_char marks the final character. An
// item is taken when start is high and busy is low. A bit-serial
// shift-subtract divider finds each digit in a pass over all VALUE_BITS
// (32) bits of the magnitude; busy stays high until the item's last
// character is sent. A base outside 2..16 gives one result with bad_radix
// set in the cycle after the transfer, and busy stays low. Results cannot
// be held off: the receiver must take every strobed character in its cycle.
module radix_integer_to_text (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rit_pkg::in_t  in_data,
  output logic          out_strobe,
  output rit_pkg::out_t out_data
);
  import rit_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_BITS-1:0]  mag_r, mag_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic                   sign_r, sign_nxt;
  logic                   qnz_r, qnz_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   ndig_r, ndig_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  out_t                   out_data_r, out_data_nxt;
  logic [STACK_W-1:0]     stack_r, stack_nxt;

  logic                   accept;
  logic                   radix_ok;
  logic [VALUE_BITS-1:0]  raw;
  logic [BASE_W:0]        rem_shift;
  logic                   q_bit;
  logic [BASE_W:0]        rem_diff;
  logic [DIGIT_W-1:0]     rem_step;
  logic                   last_bit;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  assign accept   = start && !busy;
  assign radix_ok = (in_data.radix >= RADIX_MIN) && (in_data.radix <= RADIX_MAX);
  assign raw      = in_data.value;

  // One shift-subtract step of the division by the base
  assign rem_shift = {1'b0, rem_r, mag_r[VALUE_BITS-1]};
  assign q_bit     = (rem_shift >= {1'b0, base_r});
  assign rem_diff  = rem_shift - {1'b0, base_r};
  assign rem_step  = q_bit ? rem_diff[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
  assign last_bit  = (bit_cnt_r == BIT_CNT_W'(VALUE_BITS - 1));

  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    rem_nxt        = rem_r;
    base_nxt       = base_r;
    sign_nxt       = sign_r;
    qnz_nxt        = qnz_r;
    bit_cnt_nxt    = bit_cnt_r;
    ndig_nxt       = ndig_r;
    stack_nxt      = stack_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!radix_ok) begin
            // Flag the bad base in a single result
            out_strobe_nxt         = 1'b1;
            out_data_nxt.char_code = BAD_CODE;
            out_data_nxt.last_char = 1'b1;
            out_data_nxt.bad_radix = 1'b1;
          end else begin
            // Load the magnitude and start the first digit
            mag_nxt     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
            base_nxt    = in_data.radix[BASE_W-1:0];
            sign_nxt    = raw[VALUE_BITS-1] && (in_data.radix == SIGNED_RADIX);
            rem_nxt     = '0;
            qnz_nxt     = 1'b0;
            bit_cnt_nxt = '0;
            ndig_nxt    = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // Shift the dividend through the remainder, quotient bits enter below
        mag_nxt     = {mag_r[VALUE_BITS-2:0], q_bit};
        rem_nxt     = rem_step;
        qnz_nxt     = qnz_r | q_bit;
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (last_bit) begin
          // Push the finished digit onto the digit stack
          stack_nxt   = {stack_r[STACK_W-DIGIT_W-1:0], rem_step};
          ndig_nxt    = ndig_r + DIG_CNT_W'(1);
          rem_nxt     = '0;
          qnz_nxt     = 1'b0;
          bit_cnt_nxt = '0;
          if (!(qnz_r | q_bit)) begin
            state_nxt = sign_r ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        out_strobe_nxt         = 1'b1;
        out_data_nxt.char_code = MINUS_CODE;
        out_data_nxt.last_char = 1'b0;
        out_data_nxt.bad_radix = 1'b0;
        state_nxt              = ST_EMIT;
      end
      ST_EMIT: begin
        // Drain the digits from the top of the stack
        out_strobe_nxt         = 1'b1;
        out_data_nxt.char_code = digit_char(stack_r[DIGIT_W-1:0]);
        out_data_nxt.last_char = (ndig_r == DIG_CNT_W'(1));
        out_data_nxt.bad_radix = 1'b0;
        stack_nxt              = {{DIGIT_W{1'b0}}, stack_r[STACK_W-1:DIGIT_W]};
        ndig_nxt               = ndig_r - DIG_CNT_W'(1);
        if (ndig_r == DIG_CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      bit_cnt_r    <= '0;
      ndig_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      ndig_r       <= ndig_nxt;
    end
  end

  // Datapath and digit stack
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    base_r     <= base_nxt;
    sign_r     <= sign_nxt;
    qnz_r      <= qnz_nxt;
    out_data_r <= out_data_nxt;
    stack_r    <= stack_nxt;
  end

endmodule

// ===== test/radix_integer_to_text_test.sv =====
module radix_integer_to_text_test;
  import rit_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 3;
  localparam int DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_CYCLES = 3_000_000;
  localparam int OWED_DEPTH = 256;
  localparam string DIGIT_SET = "0123456789abcdef";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_strobe;
  out_t out_data;

  // Characters still owed by the block, oldest first, in a ring
  out_t owed_mem[OWED_DEPTH];
  int owed_wr = 0;
  int owed_rd = 0;
  int error_count = 0;
  bit gaps_on = 1'b0;

  radix_integer_to_text uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Print one line per mismatch and count every one
  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // Add one character to the owed ring
  function automatic void owe_char(out_t c);
    owed_mem[owed_wr % OWED_DEPTH] = c;
    owed_wr++;
  endfunction

  // Queue the characters that one accepted conversion must produce
  function automatic void predict_text(in_t item);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base;
    logic [CHAR_BITS-1:0] digits[MAX_DIGITS];
    int n;
    int i;
    if (item.radix < RADIX_MIN || item.radix > RADIX_MAX) begin
      owe_char(out_t'{BAD_CODE, 1'b1, 1'b1});
      return;
    end
    base = VALUE_BITS'(item.radix);
    // Two's complement negate; the most negative value wraps to its exact magnitude
    mag = item.value[VALUE_BITS-1] ? VALUE_BITS'(-item.value) : VALUE_BITS'(item.value);
    // Digits come out least significant first
    n = 0;
    do begin
      digits[n] = CHAR_BITS'(DIGIT_SET[int'(mag % base)]);
      n++;
      mag = mag / base;
    end while (mag != '0);
    // Sign only for negative values in base ten
    if (item.value[VALUE_BITS-1] && item.radix == SIGNED_RADIX) begin
      owe_char(out_t'{MINUS_CODE, 1'b0, 1'b0});
    end
    for (i = n - 1; i >= 0; i--) begin
      owe_char(out_t'{digits[i], 1'(i == 0), 1'b0});
    end
  endfunction

  // Record each transfer first, then check each strobed character
  always @(posedge clk) begin : watch_block
    out_t want;
    if (rst_n && start && busy === 1'b0) begin
      predict_text(in_data);
    end
    if (rst_n && out_strobe) begin
      if (owed_wr == owed_rd) begin
        report_mismatch($sformatf("unexpected character %h", out_data));
      end else begin
        want = owed_mem[owed_rd % OWED_DEPTH];
        owed_rd++;
        if (out_data.char_code !== want.char_code) begin
          report_mismatch($sformatf("char_code %h, expected %h",
                                    out_data.char_code, want.char_code));
        end
        if (out_data.last_char !== want.last_char) begin
          report_mismatch($sformatf("last_char %b, expected %b",
                                    out_data.last_char, want.last_char));
        end
        if (out_data.bad_radix !== want.bad_radix) begin
          report_mismatch($sformatf("bad_radix %b, expected %b",
                                    out_data.bad_radix, want.bad_radix));
        end
      end
    end
  end

  // Hold one item on the input until the block takes it, then maybe idle
  task automatic convert(logic signed [VALUE_BITS-1:0] value,
                         logic [RADIX_BITS-1:0] radix);
    start <= 1'b1;
    in_data <= '{value: value, radix: radix};
    do @(posedge clk); while (busy !== 1'b0);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Zero, the value extremes and the sign rules
  task automatic test_extremes();
    convert('0, SIGNED_RADIX);
    convert('0, RADIX_MIN);
    convert(32'sh7fff_ffff, RADIX_MIN);
    convert(32'sh7fff_ffff, SIGNED_RADIX);
    // most negative value: magnitude must come out exactly
    convert(32'sh8000_0000, SIGNED_RADIX);
    convert(32'sh8000_0000, RADIX_MIN);
    convert(32'sh8000_0000, RADIX_MAX);
    convert(-1, SIGNED_RADIX);
    // negative in a base other than ten: digits only, no sign
    convert(-1, RADIX_MAX);
    convert(-305419896, 8'd7);
  endtask

  // Out-of-range bases, back to back while busy stays low
  task automatic test_bad_radix();
    gaps_on = 1'b0;
    convert($urandom, 8'd0);
    convert($urandom, 8'd1);
    convert($urandom, RADIX_MAX + 8'd1);
    convert($urandom, 8'hff);
  endtask

  // One random value in every valid base
  task automatic test_each_base();
    int b;
    for (b = RADIX_MIN; b <= RADIX_MAX; b++) begin
      convert($urandom, RADIX_BITS'(b));
    end
  endtask

  // Random values and bases; gaps switch on and off in stretches
  task automatic test_random(int count, bit with_gaps);
    int n;
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
    for (n = 0; n < count; n++) begin
      if (n % 25 == 0) begin
        gaps_on = with_gaps && $urandom_range(0, 2) != 0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: value = $urandom;
        4, 5:       value = $urandom_range(0, 1000);
        6, 7:       value = -$signed(VALUE_BITS'($urandom_range(1, 1000)));
        8:          value = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        default:    value = $urandom_range(0, 2) - 1;
      endcase
      case ($urandom_range(0, 19))
        0:       radix = RADIX_BITS'($urandom_range(0, 1));
        1, 2:    radix = RADIX_BITS'($urandom_range(RADIX_MAX + 1, 255));
        default: radix = RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX));
      endcase
      convert(value, radix);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_bad_radix();
    test_each_base();
    test_random(320, 1'b1);
    test_random(80, 1'b0);
    start <= 1'b0;
    // Let every owed character arrive, then watch for strays
    while (owed_wr != owed_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("radix_integer_to_text_test: clean");
    end else begin
      $display("radix_integer_to_text_test: errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("radix_integer_to_text_test: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rit_pkg.sv
rtl/core/radix_integer_to_text.sv
test/radix_integer_to_text_test.sv
